@@ rtl/nsa_pkg.sv @@
// Shared types and constants for the polyphonic note slot allocator.
`timescale 1ns / 1ps
`default_nettype none
package nsa_pkg;

   localparam int DEF_VOICES_PER_LINE = 8;
   localparam int DEF_NUM_LINES       = 128;

   localparam int LINE_W     = 7;
   localparam int NOTE_ID_W  = 16;
   localparam int VOLUME_W   = 7;
   localparam int SLOT_OUT_W = 3;
   localparam int STAMP_W    = 32;

   // Stored slot entry: an unsigned 17-bit note id followed by a 7-bit volume.
   localparam int ID_W      = 17;
   localparam int LEVEL_W   = 7;
   localparam int ENTRY_W   = ID_W + LEVEL_W;

   // Wide enough to hold the largest line count for range checks.
   localparam int LINE_CMP_W = 11;

   localparam logic CMD_NOTE_OFF = 1'b0;
   localparam logic CMD_NOTE_ON  = 1'b1;

   localparam logic [ID_W-1:0] RELEASED_ID = '1;

   typedef struct packed {
      logic clear_wr;
      logic load;
      logic commit;
   } ctl_cmd_type;

   typedef struct packed {
      logic clear_last;
   } dp_sts_type;

endpackage
`default_nettype wire

@@ rtl/nsa_ctrl.sv @@
// Controller state machine: clearing pass, beat acceptance and result hand-off.
`timescale 1ns / 1ps
`default_nettype none
module nsa_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output nsa_pkg::ctl_cmd_type     cmd,
   input  wire nsa_pkg::dp_sts_type sts
);
   import nsa_pkg::*;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_LOOK  = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd.clear_wr = 1'b0;
      cmd.load     = 1'b0;
      cmd.commit   = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/nsa_dpath.sv @@
// Datapath: slot row memory, slot search and update, change stamp and result register.
`timescale 1ns / 1ps
`default_nettype none
module nsa_dpath #(
   parameter int VOICES_PER_LINE = nsa_pkg::DEF_VOICES_PER_LINE,
   parameter int NUM_LINES       = nsa_pkg::DEF_NUM_LINES
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire nsa_pkg::ctl_cmd_type            cmd,
   output nsa_pkg::dp_sts_type                  sts,
   input  wire logic                            req_command,
   input  wire logic [nsa_pkg::LINE_W-1:0]      req_line,
   input  wire logic [nsa_pkg::NOTE_ID_W-1:0]   req_note_id,
   input  wire logic [nsa_pkg::VOLUME_W-1:0]    req_volume,
   input  wire logic                            req_end_of_group,
   output logic      [nsa_pkg::LINE_W-1:0]      rsp_changed_line,
   output logic      [nsa_pkg::SLOT_OUT_W-1:0]  rsp_changed_slot,
   output logic                                 rsp_no_slot_error,
   output logic      [nsa_pkg::STAMP_W-1:0]     rsp_group_stamp
);
   import nsa_pkg::*;

   localparam int LINE_AW = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
   localparam int SLOT_W  = (VOICES_PER_LINE > 1) ? $clog2(VOICES_PER_LINE) : 1;
   localparam int ROW_W   = VOICES_PER_LINE * ENTRY_W;

   logic [ROW_W-1:0] row_mem [NUM_LINES];

   logic [LINE_AW-1:0]    clr_addr_ff;
   logic [ROW_W-1:0]      rd_row_ff;
   logic                  command_ff;
   logic [LINE_W-1:0]     line_ff;
   logic [NOTE_ID_W-1:0]  note_id_ff;
   logic [VOLUME_W-1:0]   volume_ff;
   logic                  eog_ff;
   logic [STAMP_W-1:0]    stamp_ff;
   logic [STAMP_W-1:0]    stamp_in;
   logic [LINE_W-1:0]     rsp_line_ff;
   logic [SLOT_OUT_W-1:0] rsp_slot_ff;
   logic [SLOT_OUT_W-1:0] rsp_slot_in;
   logic                  rsp_err_ff;
   logic [STAMP_W-1:0]    rsp_stamp_ff;

   logic [LINE_AW+LINE_W-1:0]     req_line_wide;
   logic [LINE_AW+LINE_W-1:0]     line_wide;
   logic [LINE_AW-1:0]            req_addr;
   logic [LINE_AW-1:0]            line_addr;
   logic                          in_range;
   logic [VOICES_PER_LINE-1:0]    hit;
   logic [VOICES_PER_LINE-1:0]    sel;
   logic                          found;
   logic [SLOT_W-1:0]             slot_idx;
   logic [SLOT_W+SLOT_OUT_W-1:0]  slot_wide;
   logic                          err;
   logic [ROW_W-1:0]              new_row;
   logic                          mem_we;
   logic [LINE_AW-1:0]            mem_waddr;
   logic [ROW_W-1:0]              mem_wdata;

   assign req_line_wide = {{LINE_AW{1'b0}}, req_line};
   assign line_wide     = {{LINE_AW{1'b0}}, line_ff};
   assign req_addr      = req_line_wide[LINE_AW-1:0];
   assign line_addr     = line_wide[LINE_AW-1:0];
   assign in_range      = ({{(LINE_CMP_W-LINE_W){1'b0}}, line_ff} < LINE_CMP_W'(NUM_LINES));

   assign sts.clear_last = (clr_addr_ff == LINE_AW'(NUM_LINES - 1));

   always_comb begin
      logic [ID_W-1:0] cur;
      logic            seen;
      seen     = 1'b0;
      found    = 1'b0;
      slot_idx = '0;
      new_row  = rd_row_ff;
      for (int s = 0; s < VOICES_PER_LINE; s++) begin
         cur = rd_row_ff[s*ENTRY_W +: ID_W];
         if (command_ff == CMD_NOTE_ON) begin
            hit[s] = cur[ID_W-1] || (cur == '0);
         end else begin
            hit[s] = (cur == {1'b0, note_id_ff});
         end
         sel[s] = hit[s] && !seen;
         seen   = seen || hit[s];
         if (sel[s]) begin
            found    = 1'b1;
            slot_idx = SLOT_W'(s);
            if (command_ff == CMD_NOTE_ON) begin
               new_row[s*ENTRY_W +: ID_W]           = {1'b0, note_id_ff};
               new_row[s*ENTRY_W + ID_W +: LEVEL_W] = volume_ff;
            end else begin
               new_row[s*ENTRY_W +: ID_W] = RELEASED_ID;
            end
         end
      end
   end

   assign err         = !in_range || !found;
   assign slot_wide   = {{SLOT_OUT_W{1'b0}}, slot_idx};
   assign rsp_slot_in = err ? '0 : slot_wide[SLOT_OUT_W-1:0];
   assign stamp_in    = stamp_ff + STAMP_W'(eog_ff);

   assign mem_we    = cmd.clear_wr || (cmd.commit && !err);
   assign mem_waddr = cmd.clear_wr ? clr_addr_ff : line_addr;
   assign mem_wdata = cmd.clear_wr ? '0 : new_row;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         row_mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.load) begin
         rd_row_ff <= row_mem[req_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         command_ff <= req_command;
         line_ff    <= req_line;
         note_id_ff <= req_note_id;
         volume_ff  <= req_volume;
         eog_ff     <= req_end_of_group;
      end
      if (cmd.commit) begin
         rsp_line_ff  <= line_ff;
         rsp_slot_ff  <= rsp_slot_in;
         rsp_err_ff   <= err;
         rsp_stamp_ff <= stamp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         stamp_ff    <= '0;
      end else begin
         if (cmd.clear_wr) begin
            clr_addr_ff <= clr_addr_ff + LINE_AW'(1);
         end
         if (cmd.commit) begin
            stamp_ff <= stamp_in;
         end
      end
   end

   assign rsp_changed_line  = rsp_line_ff;
   assign rsp_changed_slot  = rsp_slot_ff;
   assign rsp_no_slot_error = rsp_err_ff;
   assign rsp_group_stamp   = rsp_stamp_ff;

endmodule
`default_nettype wire

@@ rtl/polyphonic_note_slot_allocator.sv @@
// Top level of the polyphonic note slot allocator.
// Each note line owns a row of VOICES_PER_LINE slots kept as one word of an on-chip
// memory. A note-on beat claims the first slot whose id is zero or released and stores
// the id and volume; a note-off beat releases the first slot holding the id. Every beat
// yields one result with the line, the slot, an error flag when no slot fits (or the
// line is not below NUM_LINES), and the change stamp, which counts end-of-group marks.
// For each event the line's row is first read from the memory into a register; the row
// is then searched, written back and the result registered, which waits while an
// earlier result has not been taken. A new beat is taken while a result still waits.
// After reset a clearing pass writes every row to zero, one row a cycle, during which
// req_ready stays low.
`timescale 1ns / 1ps
`default_nettype none
module polyphonic_note_slot_allocator #(
   parameter int VOICES_PER_LINE = nsa_pkg::DEF_VOICES_PER_LINE,
   parameter int NUM_LINES       = nsa_pkg::DEF_NUM_LINES
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_command,
   input  wire logic [nsa_pkg::LINE_W-1:0]      req_line,
   input  wire logic [nsa_pkg::NOTE_ID_W-1:0]   req_note_id,
   input  wire logic [nsa_pkg::VOLUME_W-1:0]    req_volume,
   input  wire logic                            req_end_of_group,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [nsa_pkg::LINE_W-1:0]      rsp_changed_line,
   output logic      [nsa_pkg::SLOT_OUT_W-1:0]  rsp_changed_slot,
   output logic                                 rsp_no_slot_error,
   output logic      [nsa_pkg::STAMP_W-1:0]     rsp_group_stamp
);
   import nsa_pkg::*;

   ctl_cmd_type cmd;
   dp_sts_type  sts;

   nsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   nsa_dpath #(
      .VOICES_PER_LINE (VOICES_PER_LINE),
      .NUM_LINES       (NUM_LINES)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_command       (req_command),
      .req_line          (req_line),
      .req_note_id       (req_note_id),
      .req_volume        (req_volume),
      .req_end_of_group  (req_end_of_group),
      .rsp_changed_line  (rsp_changed_line),
      .rsp_changed_slot  (rsp_changed_slot),
      .rsp_no_slot_error (rsp_no_slot_error),
      .rsp_group_stamp   (rsp_group_stamp)
   );

endmodule
`default_nettype wire
